// ===== src/zcrb_pkg.sv =====
`default_nettype none

package zcrb_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned RateW   = 24;
  localparam int unsigned PctW    = 7;
  localparam int unsigned SumW    = 40;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned BandW   = 15;
  localparam int unsigned DivW    = 17;
  localparam int unsigned DivSteps = SumW;
  localparam int unsigned DivCntW  = $clog2(DivSteps + 1);

  localparam logic [RateW-1:0] RateMax   = {RateW{1'b1}};
  localparam logic [16:0]      RateScale = 17'd100000;
  localparam logic [PctW-1:0]  PctMax    = 7'd100;
  localparam logic [15:0]      CountMax  = 16'hFFFF;

  localparam logic [CfgW-1:0]  WindowLenRst  = 16'd100;
  localparam logic [CfgW-1:0]  BasePeriodRst = 16'd3000;
  localparam logic [BandW-1:0] BandRst       = 15'd8;
  localparam logic [CfgW-1:0]  FullScaleRst  = 16'd250;

  typedef enum logic [1:0] {
    CFG_WINDOW_LEN  = 2'd0,
    CFG_BASE_PERIOD = 2'd1,
    CFG_HYST_BAND   = 2'd2,
    CFG_FULL_SCALE  = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_POS  = 2'd1,
    CLS_NEG  = 2'd2
  } class_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_BASE,
    ST_ADJ,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    OP_RATE,
    OP_MEAN,
    OP_PCT
  } div_op_e;

  function automatic logic [RateW-1:0] sat_rate(input logic [SumW-1:0] v);
    sat_rate = (|v[SumW-1:RateW]) ? RateMax : v[RateW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/zcrb_in_if.sv =====
`default_nettype none

interface zcrb_in_if;
  import zcrb_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      func;
  logic signed [SampleW-1:0] sample_value;

  modport source (output valid, output func, output sample_value, input ready);
  modport sink   (input valid, input func, input sample_value, output ready);
endinterface

`default_nettype wire

// ===== src/zcrb_out_if.sv =====
`default_nettype none

interface zcrb_out_if;
  import zcrb_pkg::*;

  logic             valid;
  logic             ready;
  logic [RateW-1:0] rate_adj_centihz;
  logic [PctW-1:0]  intensity_pct;
  logic             baseline_ready;
  logic [RateW-1:0] baseline_centihz;

  modport source (output valid, output rate_adj_centihz, output intensity_pct,
                  output baseline_ready, output baseline_centihz, input ready);
  modport sink   (input valid, input rate_adj_centihz, input intensity_pct,
                  input baseline_ready, input baseline_centihz, output ready);
endinterface

`default_nettype wire

// ===== src/zero_cross_rate_with_baseline.sv =====
// Zero-crossing rate meter with a startup baseline.
// in_i carries items of two kinds: a signed ADC sample (func = 0) or a one
// millisecond tick (func = 1). out_o carries one result per closed window:
// the rate above baseline, a percent of full scale and the baseline state.
// cfg_we_i / cfg_idx_i / cfg_wdata_i write the four registers; the user
// must write them only while idle, the block itself does not enforce it.
// While in_i.ready is high the block takes one sample or tick every cycle;
// a tick that closes a window keeps in_i.ready low while one shared
// restoring divider (one quotient bit per cycle) runs the rate pass and
// the percent pass, plus a mean pass on the window that freezes a baseline
// built from at least one window. The result is registered in ST_OUT after
// the last pass, and ready rises in that same cycle. A zero window length
// skips the rate pass and a zero full scale the percent pass.
// The result sits in an output register: a stalled receiver does not stop
// samples and ticks, but the next closing tick waits in ST_OUT with
// in_i.ready low until the receiver takes the result.
// Reset (asynchronous, active low) restores the register defaults, clears
// the window, the counters and the baseline; no result is pending after it.

`default_nettype none

module zero_cross_rate_with_baseline
  import zcrb_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  zcrb_in_if.sink                  in_i,
  zcrb_out_if.source               out_o,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [CfgW-1:0]     cfg_wdata_i
);

  // configuration
  logic [CfgW-1:0]  win_len_q, win_len_d;
  logic [CfgW-1:0]  base_period_q, base_period_d;
  logic [BandW-1:0] band_q, band_d;
  logic [CfgW-1:0]  full_scale_q, full_scale_d;

  // window and baseline state
  state_e           state_q, state_d;
  div_op_e          op_q, op_d;
  class_e           prev_class_q, prev_class_d;
  logic             need_first_q, need_first_d;
  logic [15:0]      rise_q, rise_d;
  logic [15:0]      elapsed_q, elapsed_d;
  logic [15:0]      since_q, since_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [15:0]      windows_q, windows_d;
  logic             frozen_q, frozen_d;
  logic [RateW-1:0] base_val_q, base_val_d;
  logic             out_valid_q, out_valid_d;

  // divider and result datapath
  logic [SumW-1:0]    num_q, num_d;
  logic [DivW-1:0]    rem_q, rem_d;
  logic [DivW-1:0]    dvs_q, dvs_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [RateW-1:0]   rate_q, rate_d;
  logic [RateW-1:0]   adj_q, adj_d;
  logic [PctW-1:0]    pct_q, pct_d;
  logic [RateW-1:0]   o_adj_q, o_adj_d;
  logic [PctW-1:0]    o_pct_q, o_pct_d;
  logic               o_rdy_q, o_rdy_d;
  logic [RateW-1:0]   o_base_q, o_base_d;

  logic signed [16:0] samp_ext;
  logic signed [16:0] band_ext;
  class_e             cls;
  logic [15:0]        elapsed_inc;
  logic [DivW:0]      shifted;
  logic               take;
  logic [SumW-1:0]    num_step;
  logic [32:0]        product;

  assign samp_ext = {in_i.sample_value[SampleW-1], in_i.sample_value};
  assign band_ext = $signed({2'b00, band_q});

  always_comb begin
    if (samp_ext > band_ext) begin
      cls = CLS_POS;
    end else if (samp_ext < -band_ext) begin
      cls = CLS_NEG;
    end else begin
      cls = CLS_ZERO;
    end
  end

  assign elapsed_inc = (elapsed_q == CountMax) ? elapsed_q : elapsed_q + 16'd1;
  assign product     = 33'(rise_q) * 33'(RateScale);

  // one restoring step of the shared divider
  assign shifted  = {rem_q, num_q[SumW-1]};
  assign take     = (shifted >= {1'b0, dvs_q});
  assign num_step = {num_q[SumW-2:0], take};

  assign in_i.ready             = (state_q == ST_IDLE);
  assign out_o.valid            = out_valid_q;
  assign out_o.rate_adj_centihz = o_adj_q;
  assign out_o.intensity_pct    = o_pct_q;
  assign out_o.baseline_ready   = o_rdy_q;
  assign out_o.baseline_centihz = o_base_q;

  always_comb begin
    win_len_d     = win_len_q;
    base_period_d = base_period_q;
    band_d        = band_q;
    full_scale_d  = full_scale_q;
    state_d       = state_q;
    op_d          = op_q;
    prev_class_d  = prev_class_q;
    need_first_d  = need_first_q;
    rise_d        = rise_q;
    elapsed_d     = elapsed_q;
    since_d       = since_q;
    sum_d         = sum_q;
    windows_d     = windows_q;
    frozen_d      = frozen_q;
    base_val_d    = base_val_q;
    out_valid_d   = out_valid_q;
    num_d         = num_q;
    rem_d         = rem_q;
    dvs_d         = dvs_q;
    cnt_d         = cnt_q;
    rate_d        = rate_q;
    adj_d         = adj_q;
    pct_d         = pct_q;
    o_adj_d       = o_adj_q;
    o_pct_d       = o_pct_q;
    o_rdy_d       = o_rdy_q;
    o_base_d      = o_base_q;

    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_WINDOW_LEN:  win_len_d     = cfg_wdata_i;
        CFG_BASE_PERIOD: base_period_d = cfg_wdata_i;
        CFG_HYST_BAND:   band_d        = cfg_wdata_i[BandW-1:0];
        CFG_FULL_SCALE:  full_scale_d  = cfg_wdata_i;
        default: ;
      endcase
    end

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          if (!in_i.func) begin
            if (need_first_q) begin
              need_first_d = 1'b0;
            end else if (prev_class_q == CLS_NEG && cls != CLS_NEG
                         && rise_q != CountMax) begin
              rise_d = rise_q + 16'd1;
            end
            prev_class_d = cls;
          end else begin
            since_d   = (since_q == CountMax) ? since_q : since_q + 16'd1;
            elapsed_d = elapsed_inc;
            if (elapsed_inc >= win_len_q) begin
              state_d = ST_MUL;
            end
          end
        end
      end
      ST_MUL: begin
        // window closes here; the product is taken before the counters clear
        rise_d       = '0;
        elapsed_d    = '0;
        prev_class_d = CLS_ZERO;
        need_first_d = 1'b1;
        if (win_len_q == '0) begin
          rate_d  = '0;
          state_d = ST_BASE;
        end else begin
          num_d   = SumW'(product);
          rem_d   = '0;
          dvs_d   = {1'b0, win_len_q};
          cnt_d   = '0;
          op_d    = OP_RATE;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        num_d = num_step;
        rem_d = take ? DivW'(shifted - {1'b0, dvs_q}) : shifted[DivW-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          case (op_q)
            OP_RATE: begin
              rate_d  = sat_rate(num_step);
              state_d = ST_BASE;
            end
            OP_MEAN: begin
              base_val_d = sat_rate(num_step);
              frozen_d   = 1'b1;
              state_d    = ST_ADJ;
            end
            OP_PCT: begin
              pct_d   = (num_step > SumW'(PctMax)) ? PctMax : num_step[PctW-1:0];
              state_d = ST_OUT;
            end
            default: state_d = ST_OUT;
          endcase
        end
      end
      ST_BASE: begin
        state_d = ST_ADJ;
        if (!frozen_q) begin
          if (since_q < base_period_q) begin
            if (windows_q != CountMax) begin
              sum_d     = sum_q + SumW'(rate_q);
              windows_d = windows_q + 16'd1;
            end
          end else if (windows_q == '0) begin
            base_val_d = '0;
            frozen_d   = 1'b1;
          end else begin
            num_d   = sum_q;
            rem_d   = '0;
            dvs_d   = {1'b0, windows_q};
            cnt_d   = '0;
            op_d    = OP_MEAN;
            state_d = ST_DIV;
          end
        end
      end
      ST_ADJ: begin
        adj_d = (rate_q > base_val_q) ? rate_q - base_val_q : '0;
        if (full_scale_q == '0) begin
          pct_d   = (rate_q > base_val_q) ? PctMax : '0;
          state_d = ST_OUT;
        end else begin
          // round to nearest: (2*adj + fs) / (2*fs)
          num_d   = SumW'({(rate_q > base_val_q) ? rate_q - base_val_q : RateW'(0), 1'b0})
                    + SumW'(full_scale_q);
          rem_d   = '0;
          dvs_d   = {full_scale_q, 1'b0};
          cnt_d   = '0;
          op_d    = OP_PCT;
          state_d = ST_DIV;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          o_adj_d     = adj_q;
          o_pct_d     = pct_q;
          o_rdy_d     = frozen_q;
          o_base_d    = base_val_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      op_q          <= OP_RATE;
      win_len_q     <= WindowLenRst;
      base_period_q <= BasePeriodRst;
      band_q        <= BandRst;
      full_scale_q  <= FullScaleRst;
      prev_class_q  <= CLS_ZERO;
      need_first_q  <= 1'b1;
      rise_q        <= '0;
      elapsed_q     <= '0;
      since_q       <= '0;
      sum_q         <= '0;
      windows_q     <= '0;
      frozen_q      <= 1'b0;
      base_val_q    <= '0;
      out_valid_q   <= 1'b0;
      cnt_q         <= '0;
    end else begin
      state_q       <= state_d;
      op_q          <= op_d;
      win_len_q     <= win_len_d;
      base_period_q <= base_period_d;
      band_q        <= band_d;
      full_scale_q  <= full_scale_d;
      prev_class_q  <= prev_class_d;
      need_first_q  <= need_first_d;
      rise_q        <= rise_d;
      elapsed_q     <= elapsed_d;
      since_q       <= since_d;
      sum_q         <= sum_d;
      windows_q     <= windows_d;
      frozen_q      <= frozen_d;
      base_val_q    <= base_val_d;
      out_valid_q   <= out_valid_d;
      cnt_q         <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q    <= num_d;
    rem_q    <= rem_d;
    dvs_q    <= dvs_d;
    rate_q   <= rate_d;
    adj_q    <= adj_d;
    pct_q    <= pct_d;
    o_adj_q  <= o_adj_d;
    o_pct_q  <= o_pct_d;
    o_rdy_q  <= o_rdy_d;
    o_base_q <= o_base_d;
  end

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_OUT)
    else $error("result appeared outside the output step");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> o_pct_q <= PctMax)
    else $error("intensity above full scale");

  a_base_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !o_rdy_q) |-> o_base_q == '0)
    else $error("baseline reported before it was frozen");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> cnt_q < DivCntW'(DivSteps))
    else $error("divider ran past its last step");

  a_adj_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT |-> adj_q <= rate_q)
    else $error("adjusted rate exceeds window rate");

endmodule

`default_nettype wire
